// ===== rtl/etok_pkg.sv =====
// Shared types, character codes and helper functions for the expression tokenizer.
// No dependencies; used by expression_tokenizer and etok_checker.

package etok_pkg;

    // Result queue size. It must hold two tokens from one byte while earlier ones wait.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Character codes the scanner recognises.
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_PLUS   = 8'h2B;
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // Scanner state.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_NUMBER = 2'd1,
        MODE_IDENT  = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

    // Token kinds as seen on the result channel.
    typedef enum logic [2:0] {
        KIND_NUMBER = 3'd0,
        KIND_IDENT  = 3'd1,
        KIND_OPER   = 3'd2,
        KIND_LPAREN = 3'd3,
        KIND_RPAREN = 3'd4,
        KIND_END    = 3'd5
    } kind_t;

    // One result transaction.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [7:0]  length;
        logic [7:0]  chr;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) ||
               ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z));
    endfunction

    function automatic logic is_oper(input logic [7:0] b);
        return (b == CHAR_PLUS) || (b == CHAR_MINUS) || (b == CHAR_STAR) ||
               (b == CHAR_SLASH) || (b == CHAR_EQUALS);
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [7:0] sat_inc8(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

endpackage

// ===== rtl/expression_tokenizer.sv =====
// Expression tokenizer top level: input byte register, scanner logic and result queue.
// Depends on etok_pkg for types, character codes and saturating helpers.

// The block takes one text byte per transaction and returns tokens on the result
// channel, one token per transaction, with last_of_run marking the final token that
// a byte caused. A byte is taken every clock while the four-entry result queue has
// at least two free entries; a byte that closes a number or identifier and also
// starts an operator, parenthesis or end token yields two tokens, so a sustained
// stream of such bytes runs at the rate the result side drains tokens. A byte first
// waits in the input register; its tokens are written to the queue when it moves on,
// and the queue head drives the result channel directly. Bytes that only extend a
// run or are whitespace give no token.
// Line and column saturate at 65535 and token length at 255.

module expression_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_ready,
    input  logic [7:0]  text_byte,
    output logic        token_valid,
    input  logic        token_ready,
    output logic [2:0]  token_kind,
    output logic [15:0] start_line,
    output logic [15:0] start_column,
    output logic [7:0]  token_length,
    output logic [7:0]  token_char,
    output logic        last_of_run
);

    localparam int unsigned DEPTH = etok_pkg::QUEUE_DEPTH;
    localparam int unsigned AW    = etok_pkg::QUEUE_AW;

    // Input register.
    logic [7:0] byte_reg;
    logic       byte_valid_reg;
    logic       advance;

    // Scanner state.
    etok_pkg::mode_t mode_reg, mode_next;
    logic [15:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] run_line_reg, run_line_next;
    logic [15:0] run_col_reg, run_col_next;
    logic [7:0]  run_len_reg, run_len_next;

    // Tokens produced by the byte in the input register.
    etok_pkg::token_t tok0, tok1;
    logic [1:0]       tok_count;

    // Result queue.
    etok_pkg::token_t queue_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             pop;

    // The byte moves on only when the queue can take two tokens.
    assign advance    = byte_valid_reg && (count_reg <= (AW+1)'(DEPTH - 2));
    assign text_ready = !byte_valid_reg || advance;
    assign pop        = token_valid && token_ready;

    // Input byte register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (text_valid && text_ready)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_valid && text_ready)
        begin
            byte_reg <= text_byte;
        end
    end

    // Scanner state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= etok_pkg::MODE_IDLE;
            line_reg     <= 16'd1;
            col_reg      <= 16'd1;
            run_line_reg <= 16'd1;
            run_col_reg  <= 16'd1;
            run_len_reg  <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            run_line_reg <= run_line_next;
            run_col_reg  <= run_col_next;
            run_len_reg  <= run_len_next;
        end
    end

    // Next state and tokens for the registered byte.
    always_comb
    begin
        logic             scan_byte;
        etok_pkg::token_t tok_new;
        logic             has_new;

        mode_next     = mode_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        run_line_next = run_line_reg;
        run_col_next  = run_col_reg;
        run_len_next  = run_len_reg;
        tok0          = '0;
        tok1          = '0;
        tok_count     = 2'd0;
        scan_byte     = 1'b1;
        tok_new       = '0;
        has_new       = 1'b0;

        // Finish or extend an open run; skipping swallows every byte, and a zero byte ends it.
        case (mode_reg)
            etok_pkg::MODE_SKIP:
            begin
                scan_byte = 1'b0;
                if (byte_reg == etok_pkg::CHAR_NUL)
                begin
                    mode_next = etok_pkg::MODE_IDLE;
                    line_next = 16'd1;
                    col_next  = 16'd1;
                end
            end
            etok_pkg::MODE_NUMBER:
            begin
                if (etok_pkg::is_digit(byte_reg) || byte_reg == etok_pkg::CHAR_DOT)
                begin
                    scan_byte    = 1'b0;
                    run_len_next = etok_pkg::sat_inc8(run_len_reg);
                    col_next     = etok_pkg::sat_inc16(col_reg);
                end
                else
                begin
                    tok0.kind   = etok_pkg::KIND_NUMBER;
                    tok0.line   = run_line_reg;
                    tok0.column = run_col_reg;
                    tok0.length = run_len_reg;
                    tok_count   = 2'd1;
                    mode_next   = etok_pkg::MODE_IDLE;
                end
            end
            etok_pkg::MODE_IDENT:
            begin
                if (etok_pkg::is_alpha(byte_reg) || etok_pkg::is_digit(byte_reg))
                begin
                    scan_byte    = 1'b0;
                    run_len_next = etok_pkg::sat_inc8(run_len_reg);
                    col_next     = etok_pkg::sat_inc16(col_reg);
                end
                else
                begin
                    tok0.kind   = etok_pkg::KIND_IDENT;
                    tok0.line   = run_line_reg;
                    tok0.column = run_col_reg;
                    tok0.length = run_len_reg;
                    tok_count   = 2'd1;
                    mode_next   = etok_pkg::MODE_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        // Classify the byte itself.
        if (scan_byte)
        begin
            tok_new.line   = line_reg;
            tok_new.column = col_reg;
            if (byte_reg == etok_pkg::CHAR_SPACE || byte_reg == etok_pkg::CHAR_TAB)
            begin
                col_next = etok_pkg::sat_inc16(col_reg);
            end
            else if (byte_reg == etok_pkg::CHAR_LF)
            begin
                line_next = etok_pkg::sat_inc16(line_reg);
                col_next  = 16'd1;
            end
            else if (byte_reg == etok_pkg::CHAR_NUL)
            begin
                tok_new.kind = etok_pkg::KIND_END;
                has_new      = 1'b1;
                line_next    = 16'd1;
                col_next     = 16'd1;
            end
            else if (etok_pkg::is_digit(byte_reg) || byte_reg == etok_pkg::CHAR_DOT ||
                     etok_pkg::is_alpha(byte_reg))
            begin
                mode_next     = etok_pkg::is_alpha(byte_reg) ? etok_pkg::MODE_IDENT
                                                             : etok_pkg::MODE_NUMBER;
                run_line_next = line_reg;
                run_col_next  = col_reg;
                run_len_next  = 8'd1;
                col_next      = etok_pkg::sat_inc16(col_reg);
            end
            else if (etok_pkg::is_oper(byte_reg) || byte_reg == etok_pkg::CHAR_LPAREN ||
                     byte_reg == etok_pkg::CHAR_RPAREN)
            begin
                if (byte_reg == etok_pkg::CHAR_LPAREN)
                begin
                    tok_new.kind = etok_pkg::KIND_LPAREN;
                end
                else if (byte_reg == etok_pkg::CHAR_RPAREN)
                begin
                    tok_new.kind = etok_pkg::KIND_RPAREN;
                end
                else
                begin
                    tok_new.kind = etok_pkg::KIND_OPER;
                end
                tok_new.length = 8'd1;
                tok_new.chr    = byte_reg;
                has_new        = 1'b1;
                col_next       = etok_pkg::sat_inc16(col_reg);
            end
            else
            begin
                // Unknown byte: end token, then ignore until a zero byte.
                tok_new.kind = etok_pkg::KIND_END;
                has_new      = 1'b1;
                mode_next    = etok_pkg::MODE_SKIP;
            end
        end

        // Place the new token behind any closed run and mark the last one.
        if (has_new)
        begin
            if (tok_count == 2'd1)
            begin
                tok1 = tok_new;
            end
            else
            begin
                tok0 = tok_new;
            end
            tok_count = tok_count + 2'd1;
        end
        tok0.last = (tok_count == 2'd1);
        tok1.last = (tok_count == 2'd2);
    end

    // Result queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (advance)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(tok_count);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (advance ? (AW+1)'(tok_count) : '0)
                                   - (pop ? (AW+1)'(1) : '0);
        end
    end

    // Result queue storage.
    always_ff @(posedge clk)
    begin
        if (advance && tok_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= tok0;
        end
        if (advance && tok_count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + AW'(1)] <= tok1;
        end
    end

    // Result channel comes straight from the queue head.
    assign token_valid  = (count_reg != '0);
    assign token_kind   = queue_reg[rd_ptr_reg].kind;
    assign start_line   = queue_reg[rd_ptr_reg].line;
    assign start_column = queue_reg[rd_ptr_reg].column;
    assign token_length = queue_reg[rd_ptr_reg].length;
    assign token_char   = queue_reg[rd_ptr_reg].chr;
    assign last_of_run  = queue_reg[rd_ptr_reg].last;

endmodule

// ===== rtl/etok_checker.sv =====
// Port-level checks for the expression tokenizer, bound to every instance.
// Depends on etok_pkg for the token kind codes.

module etok_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        text_valid,
    input logic        text_ready,
    input logic [7:0]  text_byte,
    input logic        token_valid,
    input logic        token_ready,
    input logic [2:0]  token_kind,
    input logic [15:0] start_line,
    input logic [15:0] start_column,
    input logic [7:0]  token_length,
    input logic [7:0]  token_char,
    input logic        last_of_run
);

    // A stalled input transaction keeps its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_ready |=> text_valid && $stable(text_byte))
        else $error("input transaction changed while stalled");

    // A stalled result transaction holds its token.
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && !token_ready |=> token_valid && $stable(token_kind) &&
        $stable(start_line) && $stable(start_column) && $stable(token_length) &&
        $stable(token_char) && $stable(last_of_run))
        else $error("result transaction changed while stalled");

    // End tokens carry no length and no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && token_kind == etok_pkg::KIND_END |->
        token_length == 8'd0 && token_char == 8'd0)
        else $error("end token with length or character");

    // Operators and parentheses are single characters and carry that character.
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid && (token_kind == etok_pkg::KIND_OPER ||
                        token_kind == etok_pkg::KIND_LPAREN ||
                        token_kind == etok_pkg::KIND_RPAREN) |->
        token_length == 8'd1 && token_char != 8'd0)
        else $error("operator or parenthesis token malformed");

    // Positions start at one and runs are never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        token_valid |-> start_line != 16'd0 && start_column != 16'd0 &&
        ((token_kind != etok_pkg::KIND_NUMBER && token_kind != etok_pkg::KIND_IDENT) ||
         (token_length != 8'd0 && token_char == 8'd0)))
        else $error("token position or run length invalid");

endmodule

bind expression_tokenizer etok_checker u_etok_checker (.*);
